// File: rtl/hsv565_pkg.sv
// ----------------------------------------------------------------------------
// hsv565_pkg
// Shared widths, arithmetic constants and the hue sector type for the HSV to
// RGB565 converter.
// ----------------------------------------------------------------------------
package hsv565_pkg;

   localparam int HUE_W   = 16;
   localparam int SAT_W   = 16;
   localparam int LEVEL_W = 8;
   localparam int PIXEL_W = 16;

   // Request data: hue, saturation, brightness from the lowest bit up.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   localparam logic [8:0] HUE_CYCLE   = 9'd360;
   localparam logic [5:0] SECTOR_SPAN = 6'd60;
   localparam logic [7:0] LEVEL_MAX   = 8'hFF;

   // The quotient of hue by 360 is estimated as (hue * 5825) >> 21.
   // The estimate is exact or one too small, and the remainder fixes it.
   localparam logic [12:0] RECIP_HUE       = 13'd5825;
   localparam int          RECIP_HUE_SHIFT = 21;

   // A 16-bit product divided by 255 is (x * 32897) >> 23, exact.
   localparam logic [15:0] RECIP_LEVEL       = 16'd32897;
   localparam int          RECIP_LEVEL_SHIFT = 23;

   // A product of up to 15300 divided by 60 is (y * 17477) >> 20, exact.
   localparam logic [14:0] RECIP_SPAN       = 15'd17477;
   localparam int          RECIP_SPAN_SHIFT = 20;

   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

endpackage

// File: rtl/hsv_to_rgb565_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb565_converter
// A request transfer passes the stage 1, 2, 3 and pixel registers on its way to
// its response, and one pixel is taken every cycle while no response waits;
// the four-stage datapath holds as a whole while a response waits. Reset
// clears the stage valid bits, the pipeline's data registers keep their contents.
// ----------------------------------------------------------------------------
module hsv_to_rgb565_converter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // hue [15:0], saturation [31:16], brightness [39:32]
   input  logic [hsv565_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pixel_rgb565 [15:0]
   output logic [hsv565_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import hsv565_pkg::*;

   logic       advance;
   logic [3:0] valid_ff;
   logic [3:0] valid_in;

   assign advance    = !valid_ff[3] || rsp_tready;
   assign req_tready = advance;
   assign valid_in   = {valid_ff[2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   hsv565_datapath u_datapath (
      .clock        (clock),
      .advance      (advance),
      .hue          (req_tdata[HUE_W-1:0]),
      .saturation   (req_tdata[HUE_W +: SAT_W]),
      .brightness   (req_tdata[HUE_W+SAT_W +: LEVEL_W]),
      .pixel_rgb565 (rsp_tdata)
   );

   assign rsp_tvalid = valid_ff[3];

endmodule

// File: rtl/hsv565_datapath.sv
// ----------------------------------------------------------------------------
// hsv565_datapath
// Four-stage conversion pipeline that advances on a common enable: hue
// reduction and level product, then degree and low level, then sector and
// interpolation product, then the packed pixel.
// ----------------------------------------------------------------------------
module hsv565_datapath (
   input  logic                               clock,
   input  logic                               advance,
   input  logic [hsv565_pkg::HUE_W-1:0]       hue,
   input  logic [hsv565_pkg::SAT_W-1:0]       saturation,
   input  logic [hsv565_pkg::LEVEL_W-1:0]     brightness,
   output logic [hsv565_pkg::PIXEL_W-1:0]     pixel_rgb565
);
   import hsv565_pkg::*;

   logic [7:0]       sat_clamp;
   logic [28:0]      hue_prod;
   logic [15:0]      dim_prod;

   logic [HUE_W-1:0] s1_hue_ff;
   logic [7:0]       s1_quot_ff;
   logic [15:0]      s1_dim_ff;
   logic [7:0]       s1_val_ff;

   logic [16:0]      hue_sub;
   logic [9:0]       deg_raw;
   logic [8:0]       deg;
   logic [31:0]      low_prod;

   logic [8:0]       s2_deg_ff;
   logic [7:0]       s2_low_ff;
   logic [7:0]       s2_val_ff;

   sector_type       sector;
   logic [8:0]       sector_base;
   logic [5:0]       rem;
   logic [5:0]       angle;
   logic [7:0]       span;
   logic [13:0]      span_prod;

   sector_type       s3_sector_ff;
   logic [13:0]      s3_span_ff;
   logic [7:0]       s3_low_ff;
   logic [7:0]       s3_val_ff;

   logic [28:0]      mid_prod;
   logic [7:0]       mid;
   logic [7:0]       red;
   logic [7:0]       green;
   logic [7:0]       blue;

   logic [PIXEL_W-1:0] pixel_ff;
   logic [PIXEL_W-1:0] pixel_in;

   // Stage 1: hue quotient estimate and the (255 - s) * v product.
   always_comb begin
      sat_clamp = (|saturation[15:8]) ? LEVEL_MAX : saturation[7:0];
      hue_prod  = 29'(hue) * 29'(RECIP_HUE);
      dim_prod  = 16'(LEVEL_MAX - sat_clamp) * 16'(brightness);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_hue_ff  <= hue;
         s1_quot_ff <= hue_prod[RECIP_HUE_SHIFT +: 8];
         s1_dim_ff  <= dim_prod;
         s1_val_ff  <= brightness;
      end
   end

   // Stage 2: hue modulo 360 and the low level.
   always_comb begin
      hue_sub  = 17'(s1_hue_ff) - (17'(s1_quot_ff) * 17'(HUE_CYCLE));
      deg_raw  = hue_sub[9:0];
      deg      = (deg_raw >= 10'(HUE_CYCLE)) ? 9'(deg_raw - 10'(HUE_CYCLE)) : deg_raw[8:0];
      low_prod = 32'(s1_dim_ff) * 32'(RECIP_LEVEL);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_deg_ff <= deg;
         s2_low_ff <= low_prod[RECIP_LEVEL_SHIFT +: 8];
         s2_val_ff <= s1_val_ff;
      end
   end

   // Stage 3: sector, angle and the (high - low) * angle product.
   always_comb begin
      if (s2_deg_ff < 9'd60) begin
         sector = SEC_RED;
      end else if (s2_deg_ff < 9'd120) begin
         sector = SEC_YELLOW;
      end else if (s2_deg_ff < 9'd180) begin
         sector = SEC_GREEN;
      end else if (s2_deg_ff < 9'd240) begin
         sector = SEC_CYAN;
      end else if (s2_deg_ff < 9'd300) begin
         sector = SEC_BLUE;
      end else begin
         sector = SEC_MAGENTA;
      end
      sector_base = 9'(sector) * 9'(SECTOR_SPAN);
      rem         = 6'(s2_deg_ff - sector_base);
      angle       = sector[0] ? (SECTOR_SPAN - rem) : rem;
      span        = s2_val_ff - s2_low_ff;
      span_prod   = 14'(span) * 14'(angle);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_sector_ff <= sector;
         s3_span_ff   <= span_prod;
         s3_low_ff    <= s2_low_ff;
         s3_val_ff    <= s2_val_ff;
      end
   end

   // Stage 4: middle level, channel arrangement and 5-6-5 packing.
   always_comb begin
      mid_prod = 29'(s3_span_ff) * 29'(RECIP_SPAN);
      mid      = s3_low_ff + mid_prod[RECIP_SPAN_SHIFT +: 8];
      case (s3_sector_ff)
         SEC_RED: begin
            red = s3_val_ff; green = mid; blue = s3_low_ff;
         end
         SEC_YELLOW: begin
            red = mid; green = s3_val_ff; blue = s3_low_ff;
         end
         SEC_GREEN: begin
            red = s3_low_ff; green = s3_val_ff; blue = mid;
         end
         SEC_CYAN: begin
            red = s3_low_ff; green = mid; blue = s3_val_ff;
         end
         SEC_BLUE: begin
            red = mid; green = s3_low_ff; blue = s3_val_ff;
         end
         default: begin
            red = s3_val_ff; green = s3_low_ff; blue = mid;
         end
      endcase
      pixel_in = {red[7:3], green[7:2], blue[7:3]};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel_rgb565 = pixel_ff;

endmodule

// File: rtl/hsv565_checker.sv
// ----------------------------------------------------------------------------
// hsv565_checker
// Port-level checks of the converter's handshake and pipeline control.
// ----------------------------------------------------------------------------
module hsv565_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [hsv565_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import hsv565_pkg::*;

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled response changed or dropped.");

   a_ready_follows_output : assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("Request ready does not follow the response stall.");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Response valid after reset.");

   a_no_early_rsp : assert property (@(posedge clock)
      reset ##1 !reset |-> !rsp_tvalid)
      else $error("Response appeared before the pipeline could fill.");

endmodule

bind hsv_to_rgb565_converter hsv565_checker u_checker (.*);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for hsv_to_rgb565_converter. A short table of colors runs first.
// The table covers the sector edges, hue wrap-around, saturation clamping,
// gray and black pixels. Random colors follow. Each pixel out is checked
// against the table's pixel where given, else a behavioral model. Requests
// come in random bursts and the response side stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import hsv565_pkg::*;

   localparam int          RANDOM_ITEMS = 1400;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [HUE_W-1:0]   hue;
      logic [SAT_W-1:0]   sat;
      logic [LEVEL_W-1:0] bright;
      logic               pixel_known;
      logic [PIXEL_W-1:0] pixel;
   } color_row_type;

   typedef enum int {
      PACE_FULL,
      PACE_MOSTLY,
      PACE_SPARSE,
      PACE_PERIODIC
   } pace_mode_type;

   localparam int COLOR_ROWS = 24;

   color_row_type color_table [0:COLOR_ROWS-1] = '{
      '{16'd0,     16'd0,     8'd0,   1'b1, 16'h0000},
      '{16'd0,     16'd0,     8'd255, 1'b1, 16'hFFFF},
      '{16'd45,    16'd0,     8'd128, 1'b1, 16'h8410},
      '{16'd0,     16'd255,   8'd255, 1'b1, 16'hF800},
      '{16'd60,    16'd255,   8'd255, 1'b1, 16'hFFE0},
      '{16'd120,   16'd255,   8'd255, 1'b1, 16'h07E0},
      '{16'd180,   16'd255,   8'd255, 1'b1, 16'h07FF},
      '{16'd240,   16'd255,   8'd255, 1'b1, 16'h001F},
      '{16'd300,   16'd255,   8'd255, 1'b1, 16'hF81F},
      '{16'd360,   16'd255,   8'd255, 1'b1, 16'hF800},
      '{16'd720,   16'd255,   8'd255, 1'b1, 16'hF800},
      '{16'd0,     16'd65535, 8'd255, 1'b1, 16'hF800},
      '{16'd0,     16'd256,   8'd255, 1'b1, 16'hF800},
      '{16'd359,   16'd255,   8'd255, 1'b0, 16'h0000},
      '{16'd65535, 16'd255,   8'd255, 1'b0, 16'h0000},
      '{16'd65535, 16'd65535, 8'd255, 1'b0, 16'h0000},
      '{16'd59,    16'd255,   8'd255, 1'b0, 16'h0000},
      '{16'd61,    16'd200,   8'd250, 1'b0, 16'h0000},
      '{16'd30,    16'd128,   8'd200, 1'b0, 16'h0000},
      '{16'd90,    16'd1,     8'd255, 1'b0, 16'h0000},
      '{16'd210,   16'd17,    8'd99,  1'b0, 16'h0000},
      '{16'd270,   16'd255,   8'd1,   1'b0, 16'h0000},
      '{16'd330,   16'd254,   8'd255, 1'b0, 16'h0000},
      '{16'd32768, 16'd32768, 8'd170, 1'b0, 16'h0000}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [PIXEL_W-1:0] pixel_expect_q [$];
   int                 error_count = 0;
   int unsigned        cycle_count = 0;

   hsv_to_rgb565_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic logic [PIXEL_W-1:0] hsv_pixel(input logic [HUE_W-1:0]   hue,
                                                    input logic [SAT_W-1:0]   sat,
                                                    input logic [LEVEL_W-1:0] bright);
      int unsigned s;
      int unsigned deg;
      int unsigned rem;
      int unsigned angle;
      int unsigned hi;
      int unsigned lo;
      int unsigned mid;
      int unsigned r;
      int unsigned g;
      int unsigned b;
      sector_type  sec;
      s     = (sat > LEVEL_MAX) ? LEVEL_MAX : sat;
      deg   = hue % HUE_CYCLE;
      sec   = sector_type'(deg / SECTOR_SPAN);
      rem   = deg % SECTOR_SPAN;
      angle = ((deg / SECTOR_SPAN) % 2 == 1) ? SECTOR_SPAN - rem : rem;
      hi    = bright;
      lo    = (LEVEL_MAX - s) * hi / LEVEL_MAX;
      mid   = lo + (hi - lo) * angle / SECTOR_SPAN;
      case (sec)
         SEC_RED: begin
            r = hi;  g = mid; b = lo;
         end
         SEC_YELLOW: begin
            r = mid; g = hi;  b = lo;
         end
         SEC_GREEN: begin
            r = lo;  g = hi;  b = mid;
         end
         SEC_CYAN: begin
            r = lo;  g = mid; b = hi;
         end
         SEC_BLUE: begin
            r = mid; g = lo;  b = hi;
         end
         default: begin
            r = hi;  g = lo;  b = mid;
         end
      endcase
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   // Mostly hues within one or two turns and meaningful saturation, with a
   // share of full-range values to reach every input bit and the clamp.
   function automatic color_row_type random_color();
      color_row_type row;
      int            pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         row.hue = 16'($urandom_range(0, 359));
      end else if (pick < 7) begin
         row.hue = 16'($urandom_range(360, 719));
      end else begin
         row.hue = 16'($urandom);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         row.sat = 16'($urandom_range(0, 255));
      end else if (pick == 6) begin
         row.sat = ($urandom_range(0, 1) == 1) ? 16'd255 : 16'd0;
      end else begin
         row.sat = 16'($urandom);
      end
      row.bright      = 8'($urandom);
      row.pixel_known = 1'b0;
      row.pixel       = '0;
      return row;
   endfunction

   // Called at a falling edge; returns at the rising edge of the transfer.
   task automatic send_color(input color_row_type row);
      req_tvalid <= 1'b1;
      req_tdata  <= {row.bright, row.sat, row.hue};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (row.pixel_known) begin
         pixel_expect_q.push_back(row.pixel);
      end else begin
         pixel_expect_q.push_back(hsv_pixel(row.hue, row.sat, row.bright));
      end
   endtask

   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_expect_q.size() == 0) begin
            $error("pixel_rgb565 transfer with no pixel outstanding: actual %h", rsp_tdata);
            error_count++;
         end else begin
            if (rsp_tdata !== pixel_expect_q[0]) begin
               $error("pixel_rgb565 mismatch: expected %h, actual %h",
                      pixel_expect_q[0], rsp_tdata);
               error_count++;
            end
            void'(pixel_expect_q.pop_front());
         end
      end
   end

   initial begin : rsp_pacing
      pace_mode_type mode;
      int            span;
      int unsigned   phase;
      rsp_tready = 1'b0;
      phase      = 0;
      forever begin
         mode = pace_mode_type'($urandom_range(0, 3));
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(negedge clock);
            phase++;
            case (mode)
               PACE_FULL:     rsp_tready <= 1'b1;
               PACE_MOSTLY:   rsp_tready <= ($urandom_range(0, 3) != 0);
               PACE_SPARSE:   rsp_tready <= ($urandom_range(0, 2) == 0);
               default:       rsp_tready <= (phase % 5 < 2);
            endcase
         end
      end
   end

   initial begin
      int burst_left;
      int gap;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      burst_left  = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < COLOR_ROWS; i++) begin
         send_color(color_table[i]);
         @(negedge clock);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // Hold off once until every pixel in flight has come back.
         if (i == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            while (pixel_expect_q.size() != 0) begin
               @(negedge clock);
            end
            @(negedge clock);
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         send_color(random_color());
         if (burst_left > 0) begin
            burst_left--;
         end
         @(negedge clock);
      end
      req_tvalid <= 1'b0;

      while (pixel_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
